// File: rtl/modbus_tcp_server_responder_core_defines.svh
// Assertion macros for the port-level checker of the responder.
// Depends on nothing; included by the checker.
`ifndef MODBUS_TCP_SERVER_RESPONDER_CORE_DEFINES_SVH
`define MODBUS_TCP_SERVER_RESPONDER_CORE_DEFINES_SVH

// Check a property on the rising clock, suspended while reset is high.
`define MTSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on the rising clock, including the reset cycles.
`define MTSR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/mtsr_pkg.sv
// Shared constants, codes and types of the Modbus TCP responder.
// Depends on nothing; used by mtsr_store, mtsr_addr_unit and the top level of the block.
package mtsr_pkg;

   localparam int DATA_WORDS  = 64;
   localparam int FRAME_BYTES = 512;
   localparam int RESP_BYTES  = 260;
   localparam int STORE_AW    = $clog2(DATA_WORDS);
   localparam int REQ_AW      = $clog2(FRAME_BYTES);
   localparam int RESP_AW     = $clog2(RESP_BYTES);
   localparam int MAX_BITS    = 2000;
   localparam int MAX_WORDS   = 125;
   localparam int COUNT_MAX   = 1023;

   // Transaction actions
   localparam logic [1:0] ACT_RX   = 2'd0;
   localparam logic [1:0] ACT_PULL = 2'd1;
   localparam logic [1:0] ACT_HWR  = 2'd2;
   localparam logic [1:0] ACT_HRD  = 2'd3;

   // Function codes
   localparam logic [7:0] FC_RD_COILS  = 8'd1;
   localparam logic [7:0] FC_RD_INPUTS = 8'd2;
   localparam logic [7:0] FC_RD_HOLD   = 8'd3;
   localparam logic [7:0] FC_RD_INREG  = 8'd4;
   localparam logic [7:0] FC_WR_COIL   = 8'd5;
   localparam logic [7:0] FC_WR_REG    = 8'd6;
   localparam logic [7:0] FC_WR_COILS  = 8'd15;
   localparam logic [7:0] FC_WR_REGS   = 8'd16;

   localparam logic [15:0] COIL_ON  = 16'hFF00;
   localparam logic [15:0] COIL_OFF = 16'h0000;

   // Word store access from the sequencer
   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] waddr;
      logic [15:0]         wdata;
      logic [STORE_AW-1:0] raddr;
   } store_req_type;

endpackage

// File: rtl/mtsr_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module mtsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/mtsr_store.sv
// Coil and register word store: RAM plus per-word valid bits so that reset reads zero.
// Depends on mtsr_pkg and mtsr_ram.
module mtsr_store (
   input  logic                   clock,
   input  logic                   reset,
   input  mtsr_pkg::store_req_type req,
   output logic [15:0]            rdata
);

   logic [mtsr_pkg::DATA_WORDS-1:0] valid_ff;
   logic                            rvalid_ff;
   logic [15:0]                     ram_rdata;

   mtsr_ram #(.WIDTH(16), .DEPTH(mtsr_pkg::DATA_WORDS)) u_ram (
      .clock (clock),
      .we    (req.we),
      .waddr (req.waddr),
      .wdata (req.wdata),
      .raddr (req.raddr),
      .rdata (ram_rdata)
   );

   // Track written words and register the valid bit with the read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[req.raddr];
         if (req.we) begin
            valid_ff[req.waddr] <= 1'b1;
         end
      end
   end

   assign rdata = rvalid_ff ? ram_rdata : 16'h0000;

endmodule

// File: rtl/mtsr_addr_unit.sv
// Shared address adder: start address plus loop index, with store range flags.
// Depends on mtsr_pkg.
module mtsr_addr_unit (
   input  logic [15:0] base,
   input  logic [10:0] offset,
   output logic [16:0] sum,
   output logic        word_ok,
   output logic        bit_ok
);

   assign sum     = {1'b0, base} + {6'b0, offset};
   assign word_ok = sum < 17'(mtsr_pkg::DATA_WORDS);
   assign bit_ok  = sum[16:4] < 13'(mtsr_pkg::DATA_WORDS);

endmodule

// File: rtl/modbus_tcp_server_responder_core.sv
// Modbus TCP server responder top level: request buffering, serving sequencer, response buffer.
// Depends on mtsr_pkg, mtsr_ram, mtsr_store and mtsr_addr_unit.
//
// A transaction is taken when start is high and busy is low. A request byte passes S_RXCHK,
// or, when it completes a frame, the header copy and the serving loop: header writes first,
// then a fetch and a fold or write state per coil, high and low byte states and a fetch or
// write state per register, through one shared address adder and the word store. A pull or
// host read passes S_PULL or S_HRD, then gives its result on the registered rsp_valid; a host
// write goes straight to the store. Results are strobed for one cycle and cannot be held off.
module modbus_tcp_server_responder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   input  logic [5:0]  req_host_addr,
   input  logic [15:0] req_host_data,
   output logic        rsp_valid,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [15:0] rsp_host_read_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_RXCHK, S_HDR, S_RB_RD, S_RB_BIT, S_RW_RD, S_RW_HI, S_RW_LO,
      S_WC_RD, S_WC_WR, S_MC_RQ, S_MC_WR, S_MR_RQH, S_MR_RQL, S_MR_WR, S_PULL, S_HRD
   } state_type;

   state_type   state_ff, state_in;
   logic [9:0]  count_ff, count_in;
   logic [7:0]  hdr_ff [12];
   logic [7:0]  hdr_in [12];
   logic [10:0] idx_ff, idx_in;
   logic [3:0]  k_ff, k_in;
   logic [7:0]  acc_ff, acc_in;
   logic [15:0] word_ff, word_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rq_ok_ff, rq_ok_in;
   logic        host_ok_ff, host_ok_in;
   logic        pending_ff, pending_in;
   logic [8:0]  rindex_ff, rindex_in;
   logic [8:0]  rlen_ff, rlen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        tx_valid_ff, tx_valid_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        tx_last_ff, tx_last_in;
   logic [15:0] hrd_ff, hrd_in;

   logic        accept;
   logic [9:0]  cnt_eff;
   logic [16:0] target;
   logic [7:0]  hm8, hm9, hm10, hm11, fc;
   logic [15:0] start_w, qty_raw;
   logic [10:0] q_bits, loop_q;
   logic [6:0]  q_words;
   logic [7:0]  nb, q2;
   logic        is_rbit, is_rword, is_echo;
   logic [3:0]  last_k;
   logic [8:0]  total;
   logic [7:0]  hdr_byte;
   logic [16:0] sum;
   logic        word_ok, bit_ok, last_it, finish;
   logic [9:0]  rq_idx;
   logic [7:0]  rq_byte, rq_rdata, resp_rdata;
   logic [15:0] store_rdata, wc_word, mc_word;
   logic        rq_we, resp_we;
   logic [8:0]  resp_waddr;
   logic [7:0]  resp_wdata;
   logic        host_ok;
   mtsr_pkg::store_req_type st_req;

   assign accept  = start && !busy;
   assign busy    = (state_ff != S_IDLE);
   assign cnt_eff = req_frame_start ? 10'd0 : count_ff;
   assign host_ok = {7'b0, req_host_addr} < 13'(mtsr_pkg::DATA_WORDS);

   // Decode the held header; bytes past the frame end read as zero
   assign hm8     = (count_ff > 10'd8)  ? hdr_ff[8]  : 8'h00;
   assign hm9     = (count_ff > 10'd9)  ? hdr_ff[9]  : 8'h00;
   assign hm10    = (count_ff > 10'd10) ? hdr_ff[10] : 8'h00;
   assign hm11    = (count_ff > 10'd11) ? hdr_ff[11] : 8'h00;
   assign fc      = hdr_ff[7];
   assign start_w = {hm8, hm9};
   assign qty_raw = {hm10, hm11};
   assign target  = {1'b0, hdr_ff[4], hdr_ff[5]} + 17'd6;
   assign q_bits  = (qty_raw > 16'(mtsr_pkg::MAX_BITS)) ? 11'(mtsr_pkg::MAX_BITS)
                                                         : qty_raw[10:0];
   assign q_words = (qty_raw > 16'(mtsr_pkg::MAX_WORDS)) ? 7'(mtsr_pkg::MAX_WORDS)
                                                          : qty_raw[6:0];
   assign nb      = 8'((12'(q_bits) + 12'd7) >> 3);
   assign q2      = {q_words, 1'b0};
   assign is_rbit  = (fc == mtsr_pkg::FC_RD_COILS) || (fc == mtsr_pkg::FC_RD_INPUTS);
   assign is_rword = (fc == mtsr_pkg::FC_RD_HOLD) || (fc == mtsr_pkg::FC_RD_INREG);
   assign is_echo  = (fc == mtsr_pkg::FC_WR_COIL) || (fc == mtsr_pkg::FC_WR_REG) ||
                     (fc == mtsr_pkg::FC_WR_COILS) || (fc == mtsr_pkg::FC_WR_REGS);
   assign last_k  = is_echo ? 4'd11 : 4'd8;
   assign total   = is_rbit ? (9'd9 + 9'(nb)) : is_rword ? (9'd9 + 9'(q2)) : 9'd12;
   assign loop_q  = is_rbit || (fc == mtsr_pkg::FC_WR_COILS) ? q_bits : 11'(q_words);
   assign last_it = (idx_ff + 11'd1) == loop_q;

   // Response header byte for the copy step
   always_comb begin
      case (k_ff)
         4'd4:    hdr_byte = 8'h00;
         4'd5:    hdr_byte = is_rbit ? (nb + 8'd3) : is_rword ? (q2 + 8'd3) : 8'd6;
         4'd8:    hdr_byte = is_rbit ? nb : is_rword ? q2 : hm8;
         4'd9:    hdr_byte = hm9;
         4'd10:   hdr_byte = hm10;
         4'd11:   hdr_byte = hm11;
         default: hdr_byte = hdr_ff[k_ff];
      endcase
   end

   mtsr_addr_unit u_addr (
      .base    (start_w),
      .offset  (idx_ff),
      .sum     (sum),
      .word_ok (word_ok),
      .bit_ok  (bit_ok)
   );

   // Request byte index for the multi-write loops
   always_comb begin
      case (state_ff)
         S_MR_RQH: rq_idx = 10'd13 + 10'({idx_ff[6:0], 1'b0});
         S_MR_RQL: rq_idx = 10'd14 + 10'({idx_ff[6:0], 1'b0});
         default:  rq_idx = 10'd13 + 10'(idx_ff[10:3]);
      endcase
   end

   assign rq_byte = rq_ok_ff ? rq_rdata : 8'h00;
   assign wc_word = (qty_raw == mtsr_pkg::COIL_ON) ? (store_rdata | (16'h1 << sum[3:0]))
                                                   : (store_rdata & ~(16'h1 << sum[3:0]));
   assign mc_word = rq_byte[idx_ff[2:0]] ? (store_rdata | (16'h1 << sum[3:0]))
                                         : (store_rdata & ~(16'h1 << sum[3:0]));

   mtsr_ram #(.WIDTH(8), .DEPTH(mtsr_pkg::FRAME_BYTES)) u_req_ram (
      .clock (clock),
      .we    (rq_we),
      .waddr (cnt_eff[mtsr_pkg::REQ_AW-1:0]),
      .wdata (req_rx_byte),
      .raddr (rq_idx[mtsr_pkg::REQ_AW-1:0]),
      .rdata (rq_rdata)
   );

   mtsr_ram #(.WIDTH(8), .DEPTH(mtsr_pkg::RESP_BYTES)) u_resp_ram (
      .clock (clock),
      .we    (resp_we),
      .waddr (resp_waddr),
      .wdata (resp_wdata),
      .raddr (rindex_ff),
      .rdata (resp_rdata)
   );

   mtsr_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rdata (store_rdata)
   );

   // Sequencer next state
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      hdr_in     = hdr_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      acc_in     = acc_ff;
      word_in    = word_ff;
      byte_in    = byte_ff;
      rq_ok_in   = rq_ok_ff;
      host_ok_in = host_ok_ff;
      pending_in = pending_ff;
      rindex_in  = rindex_ff;
      rlen_in    = rlen_ff;
      rsp_valid_in = 1'b0;
      tx_valid_in  = tx_valid_ff;
      tx_byte_in   = tx_byte_ff;
      tx_last_in   = tx_last_ff;
      hrd_in       = hrd_ff;
      finish     = 1'b0;
      rq_we      = 1'b0;
      resp_we    = 1'b0;
      resp_waddr = 9'd0;
      resp_wdata = 8'h00;
      st_req.we    = 1'b0;
      st_req.waddr = sum[mtsr_pkg::STORE_AW-1:0];
      st_req.wdata = 16'h0000;
      st_req.raddr = sum[mtsr_pkg::STORE_AW+3:4];
      case (state_ff)
         S_IDLE: begin
            st_req.raddr = req_host_addr[mtsr_pkg::STORE_AW-1:0];
            if (accept) begin
               case (req_action)
                  mtsr_pkg::ACT_RX: begin
                     count_in = cnt_eff;
                     if (cnt_eff < 10'(mtsr_pkg::COUNT_MAX)) begin
                        count_in = cnt_eff + 10'd1;
                        rq_we    = cnt_eff < 10'(mtsr_pkg::FRAME_BYTES);
                        if (cnt_eff < 10'd12) begin
                           hdr_in[cnt_eff[3:0]] = req_rx_byte;
                        end
                        state_in = S_RXCHK;
                     end
                  end
                  mtsr_pkg::ACT_PULL: state_in = S_PULL;
                  mtsr_pkg::ACT_HWR: begin
                     st_req.we    = host_ok;
                     st_req.waddr = req_host_addr[mtsr_pkg::STORE_AW-1:0];
                     st_req.wdata = req_host_data;
                  end
                  default: begin
                     host_ok_in = host_ok;
                     state_in   = S_HRD;
                  end
               endcase
            end
         end
         S_RXCHK: begin
            state_in = S_IDLE;
            if (count_ff >= 10'd6 && {7'b0, count_ff} == target && target >= 17'd8 &&
                target <= 17'(mtsr_pkg::FRAME_BYTES)) begin
               pending_in = 1'b0;
               rindex_in  = 9'd0;
               rlen_in    = 9'd0;
               idx_in     = 11'd0;
               acc_in     = 8'h00;
               k_in       = 4'd0;
               if (is_rbit || is_rword || is_echo) begin
                  state_in = S_HDR;
               end
            end
         end
         S_HDR: begin
            resp_we    = 1'b1;
            resp_waddr = 9'(k_ff);
            resp_wdata = hdr_byte;
            k_in       = k_ff + 4'd1;
            if (k_ff == last_k) begin
               if (is_rbit) begin
                  if (q_bits == 11'd0) finish = 1'b1;
                  else state_in = S_RB_RD;
               end else if (is_rword) begin
                  if (q_words == 7'd0) finish = 1'b1;
                  else state_in = S_RW_RD;
               end else if (fc == mtsr_pkg::FC_WR_COIL) begin
                  state_in = S_WC_RD;
               end else if (fc == mtsr_pkg::FC_WR_REG) begin
                  st_req.we    = word_ok;
                  st_req.wdata = qty_raw;
                  finish       = 1'b1;
               end else if (fc == mtsr_pkg::FC_WR_COILS) begin
                  if (q_bits == 11'd0) finish = 1'b1;
                  else state_in = S_MC_RQ;
               end else begin
                  if (q_words == 7'd0) finish = 1'b1;
                  else state_in = S_MR_RQH;
               end
            end
         end
         // Read coils: fetch the word, then fold its bit into the data byte
         S_RB_RD: state_in = S_RB_BIT;
         S_RB_BIT: begin
            acc_in = acc_ff | (8'((bit_ok && store_rdata[sum[3:0]]) ? 1 : 0) << idx_ff[2:0]);
            if (idx_ff[2:0] == 3'd7 || last_it) begin
               resp_we    = 1'b1;
               resp_waddr = 9'd9 + 9'(idx_ff[10:3]);
               resp_wdata = acc_in;
               acc_in     = 8'h00;
            end
            idx_in = idx_ff + 11'd1;
            if (last_it) finish = 1'b1;
            else state_in = S_RB_RD;
         end
         // Read registers: high byte, then low byte
         S_RW_RD: begin
            st_req.raddr = sum[mtsr_pkg::STORE_AW-1:0];
            state_in     = S_RW_HI;
         end
         S_RW_HI: begin
            word_in    = word_ok ? store_rdata : 16'h0000;
            resp_we    = 1'b1;
            resp_waddr = 9'd9 + 9'({idx_ff[6:0], 1'b0});
            resp_wdata = word_in[15:8];
            state_in   = S_RW_LO;
         end
         S_RW_LO: begin
            resp_we    = 1'b1;
            resp_waddr = 9'd10 + 9'({idx_ff[6:0], 1'b0});
            resp_wdata = word_ff[7:0];
            idx_in     = idx_ff + 11'd1;
            if (last_it) finish = 1'b1;
            else state_in = S_RW_RD;
         end
         // Write single coil: read-modify-write
         S_WC_RD: begin
            if (bit_ok && (qty_raw == mtsr_pkg::COIL_ON || qty_raw == mtsr_pkg::COIL_OFF)) begin
               state_in = S_WC_WR;
            end else begin
               finish = 1'b1;
            end
         end
         S_WC_WR: begin
            st_req.we    = 1'b1;
            st_req.waddr = sum[mtsr_pkg::STORE_AW+3:4];
            st_req.wdata = wc_word;
            finish       = 1'b1;
         end
         // Write coils: fetch the request byte and the word together
         S_MC_RQ: begin
            rq_ok_in = rq_idx < count_ff;
            state_in = S_MC_WR;
         end
         S_MC_WR: begin
            st_req.we    = bit_ok;
            st_req.waddr = sum[mtsr_pkg::STORE_AW+3:4];
            st_req.wdata = mc_word;
            idx_in       = idx_ff + 11'd1;
            if (last_it) finish = 1'b1;
            else state_in = S_MC_RQ;
         end
         // Write registers: two request bytes, then the word
         S_MR_RQH: begin
            rq_ok_in = rq_idx < count_ff;
            state_in = S_MR_RQL;
         end
         S_MR_RQL: begin
            byte_in  = rq_byte;
            rq_ok_in = rq_idx < count_ff;
            state_in = S_MR_WR;
         end
         S_MR_WR: begin
            st_req.we    = word_ok;
            st_req.wdata = {byte_ff, rq_byte};
            idx_in       = idx_ff + 11'd1;
            if (last_it) finish = 1'b1;
            else state_in = S_MR_RQH;
         end
         S_PULL: begin
            rsp_valid_in = 1'b1;
            hrd_in       = 16'h0000;
            tx_valid_in  = 1'b0;
            tx_byte_in   = 8'h00;
            tx_last_in   = 1'b0;
            if (pending_ff && rindex_ff < rlen_ff) begin
               tx_valid_in = 1'b1;
               tx_byte_in  = resp_rdata;
               if (rindex_ff + 9'd1 >= rlen_ff) begin
                  tx_last_in = 1'b1;
                  pending_in = 1'b0;
                  rindex_in  = 9'd0;
               end else begin
                  rindex_in = rindex_ff + 9'd1;
               end
            end
            state_in = S_IDLE;
         end
         S_HRD: begin
            rsp_valid_in = 1'b1;
            tx_valid_in  = 1'b0;
            tx_byte_in   = 8'h00;
            tx_last_in   = 1'b0;
            hrd_in       = host_ok_ff ? store_rdata : 16'h0000;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // Arm the response once the serving loop ends
      if (finish) begin
         pending_in = 1'b1;
         rlen_in    = total;
         rindex_in  = 9'd0;
         state_in   = S_IDLE;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= 10'd0;
         pending_ff   <= 1'b0;
         rindex_ff    <= 9'd0;
         rlen_ff      <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rindex_ff    <= rindex_in;
         rlen_ff      <= rlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_ff      <= hdr_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      word_ff     <= word_in;
      byte_ff     <= byte_in;
      rq_ok_ff    <= rq_ok_in;
      host_ok_ff  <= host_ok_in;
      tx_valid_ff <= tx_valid_in;
      tx_byte_ff  <= tx_byte_in;
      tx_last_ff  <= tx_last_in;
      hrd_ff      <= hrd_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_valid       = tx_valid_ff;
   assign rsp_tx_byte        = tx_byte_ff;
   assign rsp_tx_last        = tx_last_ff;
   assign rsp_host_read_data = hrd_ff;

endmodule

// File: rtl/mtsr_checker.sv
// Port-level checks of the responder and the bind that attaches them.
// Depends on modbus_tcp_server_responder_core_defines.svh and the top level.
`include "modbus_tcp_server_responder_core_defines.svh"

module mtsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_tx_last,
   input logic [15:0] rsp_host_read_data
);

   // A result comes only after a taken pull or host read
   `MTSR_ASSERT(a_rsp_after_cmd, rsp_valid |-> $past(start && !busy && req_action[0], 2), "result without a pull or host read")
   // Every pull or host read gives a result
   `MTSR_ASSERT(a_cmd_gives_rsp, (start && !busy && req_action[0]) |=> ##1 rsp_valid, "pull or host read dropped")
   // A result with no byte, from an empty pull or a host read, shows a quiet byte lane
   `MTSR_ASSERT(a_empty_quiet, (rsp_valid && !rsp_tx_valid) |-> (rsp_tx_byte == 8'h00 && !rsp_tx_last), "idle byte lane not zero")
   // A response byte carries no host word
   `MTSR_ASSERT(a_byte_no_word, (rsp_valid && rsp_tx_valid) |-> (rsp_host_read_data == 16'h0000), "host word on a pull")
   // Reset leaves the block free to take a transaction
   `MTSR_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy, "busy straight after reset")

endmodule

bind modbus_tcp_server_responder_core mtsr_checker u_mtsr_checker (.*);

// File: verif/modbus_responder_checker.sv
`timescale 1ns / 100ps
// Checker for the Modbus TCP responder: watches both channels, predicts every result.
// Depends on mtsr_pkg; instantiated beside the block by tb.
module modbus_responder_checker
   import mtsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   input  logic [5:0]  req_host_addr,
   input  logic [15:0] req_host_data,
   input  logic        rsp_valid,
   input  logic        rsp_tx_valid,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_tx_last,
   input  logic [15:0] rsp_host_read_data,
   output int          fail_count,
   output int          outstanding
);

   typedef struct {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [15:0] read_word;
   } reply_type;

   reply_type    expected_replies[$];
   logic [7:0]   frame_buf[FRAME_BYTES];
   logic [15:0]  store_words[DATA_WORDS];
   logic [7:0]   reply_buf[RESP_BYTES];
   int unsigned  rx_count;
   bit           reply_pending;
   int unsigned  reply_idx;
   int unsigned  reply_len;

   assign outstanding = expected_replies.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int unsigned frame_at(input int unsigned i, input int unsigned n);
      return (i < n && i < FRAME_BYTES) ? int'(frame_buf[i]) : 0;
   endfunction

   function automatic int unsigned coil_get(input int unsigned n);
      if (n / 16 >= DATA_WORDS) return 0;
      return (store_words[n / 16] >> (n % 16)) & 1;
   endfunction

   task automatic coil_put(input int unsigned n, input bit v);
      if (n / 16 < DATA_WORDS) store_words[n / 16][n % 16] = v;
   endtask

   function automatic int unsigned word_get(input int unsigned a);
      return (a < DATA_WORDS) ? int'(store_words[a]) : 0;
   endfunction

   task automatic word_put(input int unsigned a, input int unsigned v);
      if (a < DATA_WORDS) store_words[a] = v[15:0];
   endtask

   // Echo header and address/value bytes for the write functions
   task automatic echo_write(input int unsigned n);
      reply_buf[4] = 8'd0;
      reply_buf[5] = 8'd6;
      for (int unsigned i = 8; i < 12; i++) reply_buf[i] = 8'(frame_at(i, n));
   endtask

   // Execute one complete frame and build its reply
   task automatic serve_frame(input int unsigned n);
      int unsigned fc, addr, qty, total, nb, w;
      fc    = frame_at(7, n);
      addr  = (frame_at(8, n) << 8) | frame_at(9, n);
      qty   = (frame_at(10, n) << 8) | frame_at(11, n);
      total = 0;
      reply_pending = 0;
      reply_idx = 0;
      reply_len = 0;
      for (int unsigned i = 0; i < 8; i++) reply_buf[i] = 8'(frame_at(i, n));
      if (fc == FC_RD_COILS || fc == FC_RD_INPUTS) begin
         if (qty > MAX_BITS) qty = MAX_BITS;
         nb = (qty + 7) / 8;
         for (int unsigned i = 0; i < nb; i++) reply_buf[9 + i] = 8'd0;
         for (int unsigned i = 0; i < qty; i++)
            if (coil_get(addr + i)) reply_buf[9 + i / 8][i % 8] = 1'b1;
         reply_buf[4] = 8'd0;
         reply_buf[5] = 8'(nb + 3);
         reply_buf[8] = 8'(nb);
         total = 9 + nb;
      end else if (fc == FC_RD_HOLD || fc == FC_RD_INREG) begin
         if (qty > MAX_WORDS) qty = MAX_WORDS;
         for (int unsigned i = 0; i < qty; i++) begin
            w = word_get(addr + i);
            reply_buf[9 + 2 * i]  = w[15:8];
            reply_buf[10 + 2 * i] = w[7:0];
         end
         reply_buf[4] = 8'd0;
         reply_buf[5] = 8'(2 * qty + 3);
         reply_buf[8] = 8'(2 * qty);
         total = 9 + 2 * qty;
      end else if (fc == FC_WR_COIL) begin
         if (qty == COIL_ON) coil_put(addr, 1'b1);
         else if (qty == COIL_OFF) coil_put(addr, 1'b0);
         echo_write(n);
         total = 12;
      end else if (fc == FC_WR_REG) begin
         word_put(addr, qty);
         echo_write(n);
         total = 12;
      end else if (fc == FC_WR_COILS) begin
         if (qty > MAX_BITS) qty = MAX_BITS;
         for (int unsigned i = 0; i < qty; i++)
            coil_put(addr + i, 1'((frame_at(13 + i / 8, n) >> (i % 8)) & 1));
         echo_write(n);
         total = 12;
      end else if (fc == FC_WR_REGS) begin
         if (qty > MAX_WORDS) qty = MAX_WORDS;
         for (int unsigned i = 0; i < qty; i++)
            word_put(addr + i, (frame_at(13 + 2 * i, n) << 8) | frame_at(14 + 2 * i, n));
         echo_write(n);
         total = 12;
      end
      if (total != 0) begin
         reply_pending = 1;
         reply_len = total;
      end
   endtask

   // Advance the prediction by one accepted transaction
   task automatic predict_transaction();
      reply_type   r;
      int unsigned target;
      r = '{1'b0, 8'd0, 1'b0, 16'd0};
      case (req_action)
         ACT_RX: begin
            if (req_frame_start) rx_count = 0;
            if (rx_count < COUNT_MAX) begin
               if (rx_count < FRAME_BYTES) frame_buf[rx_count] = req_rx_byte;
               rx_count++;
               if (rx_count >= 6) begin
                  target = {frame_buf[4], frame_buf[5]} + 6;
                  if (rx_count == target && target >= 8 && target <= FRAME_BYTES)
                     serve_frame(target);
               end
            end
         end
         ACT_HWR: word_put(req_host_addr, req_host_data);
         ACT_HRD: begin
            r.read_word = store_words[req_host_addr];
            expected_replies.push_back(r);
         end
         default: begin
            if (reply_pending && reply_idx < reply_len && reply_idx < RESP_BYTES) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = reply_buf[reply_idx];
               reply_idx++;
               if (reply_idx >= reply_len) begin
                  r.tx_last = 1'b1;
                  reply_pending = 0;
                  reply_idx = 0;
               end
            end
            expected_replies.push_back(r);
         end
      endcase
   endtask

   // Compare results first, then predict the transaction taken at the same edge
   always @(posedge clock) begin
      reply_type w;
      if (reset) begin
         expected_replies.delete();
         foreach (store_words[i]) store_words[i] = '0;
         foreach (frame_buf[i]) frame_buf[i] = '0;
         foreach (reply_buf[i]) reply_buf[i] = '0;
         rx_count = 0;
         reply_pending = 0;
         reply_idx = 0;
         reply_len = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected result, tx_byte", rsp_tx_byte, 0);
            end else begin
               w = expected_replies.pop_front();
               if (rsp_tx_valid !== w.tx_valid)
                  report_mismatch("tx_valid", rsp_tx_valid, w.tx_valid);
               if (rsp_tx_byte !== w.tx_byte)
                  report_mismatch("tx_byte", rsp_tx_byte, w.tx_byte);
               if (rsp_tx_last !== w.tx_last)
                  report_mismatch("tx_last", rsp_tx_last, w.tx_last);
               if (rsp_host_read_data !== w.read_word)
                  report_mismatch("host_read_data", rsp_host_read_data, w.read_word);
            end
         end
         if (start && !busy) predict_transaction();
      end
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the Modbus TCP responder: clock, reset, frame stimulus and verdict.
// Depends on mtsr_pkg, the responder core and modbus_responder_checker.
module tb;
   import mtsr_pkg::*;

   localparam int ITEM_TARGET = 550;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_PULL;
   logic [7:0]  req_rx_byte = '0;
   logic        req_frame_start = 1'b0;
   logic [5:0]  req_host_addr = '0;
   logic [15:0] req_host_data = '0;
   logic        rsp_valid, rsp_tx_valid, rsp_tx_last;
   logic [7:0]  rsp_tx_byte;
   logic [15:0] rsp_host_read_data;
   int          fail_count, outstanding;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          burst_mode = 0;

   always #2 clock = ~clock;

   modbus_tcp_server_responder_core dut (.*);
   modbus_responder_checker checker_i (.*);

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one transaction and hold it until the block takes it
   task automatic issue(input logic [1:0] act, input logic [7:0] rx, input bit fs,
                        input logic [5:0] ha, input logic [15:0] hd);
      int  gap;
      bit  was_busy;
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_rx_byte     <= rx;
      req_frame_start <= fs;
      req_host_addr   <= ha;
      req_host_data   <= hd;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      items_sent++;
   endtask

   task automatic pull_bytes(input int count);
      for (int i = 0; i < count; i++)
         issue(ACT_PULL, 8'($urandom), 1'b0, 6'($urandom), 16'($urandom));
   endtask

   // Build a request frame; a negative len_field gives the true length
   task automatic send_frame(input logic [7:0] fc, input int unsigned addr,
                             input int unsigned qty, input int len_field,
                             input int cut, input int pulls);
      logic [7:0]  bytes_q[$];
      int unsigned n, clip;
      bytes_q = {8'($urandom), 8'($urandom),
                 ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0,
                 8'd0, 8'd0, 8'($urandom), fc, addr[15:8], addr[7:0], qty[15:8], qty[7:0]};
      if (fc == FC_WR_COILS) begin
         clip = (qty > MAX_BITS) ? MAX_BITS : qty;
         n = (clip + 7) / 8;
         bytes_q.push_back(n[7:0]);
         repeat (n) bytes_q.push_back(8'($urandom));
      end else if (fc == FC_WR_REGS) begin
         clip = (qty > MAX_WORDS) ? MAX_WORDS : qty;
         bytes_q.push_back(8'(2 * clip));
         repeat (2 * clip) bytes_q.push_back(8'($urandom));
      end
      n = (len_field < 0) ? bytes_q.size() - 6 : len_field;
      bytes_q[4] = n[15:8];
      bytes_q[5] = n[7:0];
      if (cut > 0 && cut < bytes_q.size()) bytes_q = bytes_q[0:cut-1];
      foreach (bytes_q[i])
         issue(ACT_RX, bytes_q[i], i == 0, 6'($urandom), 16'($urandom));
      pull_bytes(pulls);
   endtask

   function automatic int unsigned rand_qty(input bit words);
      if ($urandom_range(0, 12) == 0) return $urandom_range(0, 65535);
      return words ? $urandom_range(0, 10) : $urandom_range(0, 40);
   endfunction

   function automatic int unsigned rand_addr(input bit words);
      if ($urandom_range(0, 10) == 0) return $urandom_range(0, 65535);
      return words ? $urandom_range(0, 70) : $urandom_range(0, 1100);
   endfunction

   initial begin
      logic [7:0] fc_set[8];
      logic [7:0] fc;
      int         pick;
      fc_set = '{FC_RD_COILS, FC_RD_INPUTS, FC_RD_HOLD, FC_RD_INREG,
                 FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: host port extremes, every function, the special cases
      issue(ACT_PULL, 8'd0, 0, 6'd0, 16'd0);
      issue(ACT_HWR, 8'd0, 0, 6'd0, 16'hFFFF);
      issue(ACT_HWR, 8'd0, 0, 6'd63, 16'hA5C3);
      issue(ACT_HRD, 8'd0, 0, 6'd63, 16'd0);
      send_frame(FC_RD_COILS, 0, 20, -1, 0, 12);
      send_frame(FC_RD_INPUTS, 1000, 40, -1, 0, 15);
      send_frame(FC_RD_HOLD, 62, 4, -1, 0, 18);
      send_frame(FC_RD_INREG, 0, 0, -1, 0, 10);
      send_frame(FC_WR_COIL, 17, COIL_ON, -1, 0, 12);
      send_frame(FC_WR_COIL, 0, COIL_OFF, -1, 0, 12);
      send_frame(FC_WR_COIL, 18, 16'h1234, -1, 0, 12);
      send_frame(FC_WR_REG, 5, 16'hBEEF, -1, 0, 12);
      send_frame(FC_WR_COILS, 1020, 12, -1, 0, 12);
      send_frame(FC_WR_REGS, 61, 5, -1, 0, 13);
      send_frame(FC_RD_COILS, 0, 16'hFFFF, -1, 0, 30);
      send_frame(FC_RD_HOLD, 0, 16'hFFFF, -1, 0, 5);
      send_frame(FC_RD_HOLD, 16'hFFFF, 3, -1, 0, 16);
      send_frame(8'd99, 0, 1, -1, 0, 2);
      send_frame(FC_RD_HOLD, 0, 1, 1, 0, 2);
      send_frame(FC_WR_REGS, 8, 3, 6, 0, 13);
      send_frame(FC_RD_HOLD, 0, 2, 16'hFFFF, 0, 1);
      issue(ACT_HRD, 8'd0, 0, 6'd0, 16'd0);

      // Random: mostly well-formed frames, some host traffic, noise and broken frames
      while (items_sent < ITEM_TARGET) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         fc = fc_set[$urandom_range(0, 7)];
         if (pick < 60) begin
            send_frame(fc, rand_addr(fc inside {FC_RD_HOLD, FC_RD_INREG, FC_WR_REG, FC_WR_REGS}),
                       (fc == FC_WR_COIL && $urandom_range(0, 1)) ?
                          (($urandom_range(0, 1)) ? COIL_ON : COIL_OFF) :
                          rand_qty(fc inside {FC_RD_HOLD, FC_RD_INREG, FC_WR_REGS}),
                       -1, 0, $urandom_range(0, 16));
         end else if (pick < 70) begin
            issue(ACT_HWR, 8'($urandom), 1'($urandom), 6'($urandom), 16'($urandom));
         end else if (pick < 80) begin
            issue(ACT_HRD, 8'($urandom), 1'($urandom), 6'($urandom), 16'($urandom));
         end else if (pick < 87) begin
            issue(ACT_RX, 8'($urandom), 1'($urandom), 6'($urandom), 16'($urandom));
         end else if (pick < 94) begin
            send_frame(fc, rand_addr(0), rand_qty(1), -1, $urandom_range(1, 11),
                       $urandom_range(0, 3));
         end else begin
            send_frame(8'($urandom), rand_addr(1), rand_qty(1),
                       ($urandom_range(0, 1)) ? $urandom_range(0, 8) : -1, 0,
                       $urandom_range(0, 4));
         end
      end
      burst_mode = 0;
      pull_bytes(3);

      // Drain and let the block settle
      @(posedge clock);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
